// ===== rtl/ttf_pkg.sv =====
// Package for the triangle tangent frame block: widths and constants.
`timescale 1ns / 1ps
`default_nettype none
package ttf_pkg;
  localparam int POS_W   = 24;            // position, Q8.16
  localparam int TEX_W   = 20;            // texture coordinate, Q4.16
  localparam int VEC_W   = 16;            // output component, Q1.15
  localparam int EPS_W   = 20;            // threshold register
  localparam int EDGE_W  = POS_W + 1;     // position difference
  localparam int DTEX_W  = TEX_W + 1;     // texture difference
  localparam int DET_W   = 2 * DTEX_W + 1;
  localparam int RAW_W   = 48;            // raw tangent / binormal / cross
  localparam int MUL_W   = 32;            // shared multiplier operand
  localparam int ACC_W   = 2 * MUL_W;
  localparam int MAG_TOP = 29;            // normalized magnitude top bit
  localparam int DIV_W   = 50;            // divider remainder
  localparam int Q_W     = 18;            // raw quotient
  localparam int Q_TOP   = Q_W - 1;
  localparam logic [EPS_W-1:0] EPS_RESET = 20'd4295;
  localparam logic [Q_W-1:0]   QMAX      = Q_W'((1 << (VEC_W - 1)) - 1);
  localparam int MSTEP_CROSS = 14;        // first cross product step
  localparam int MSTEP_LAST  = 19;
  localparam logic [1:0] JOB_TAN = 2'd0;
  localparam logic [1:0] JOB_BIN = 2'd1;
  localparam logic [1:0] JOB_NRM = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/triangle_tangent_frame_top.sv =====
// Top level: per-triangle tangent, binormal and normal on one shared multiplier.
// First and second corners of a triangle are stored and give no result.
// Third corner: edge and UV differences, the tangent and binormal multiplies, their
// normalizations, the cross product multiplies, the normal's normalization and output.
// A zero vector normalizes at once, else by alignment shifts, squares, square-root and
// divide steps. No new corner is taken until the frame goes to the output register,
// which waits while m_tvalid is held without m_tready.
// Reset (rst, synchronous, active high): corner count 0, threshold 4295, no result.
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_frame_top (
  input  wire logic         clk,
  input  wire logic         rst,
  // config write: uv_area_epsilon
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [19:0]  cfg_data,
  // vertex in: tdata = pos_x, pos_y, pos_z, tex_u, tex_v (lowest first)
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [111:0] s_tdata,
  input  wire logic         s_tlast,   // last_vertex
  // frame out: tdata = tangent_x/y/z, binormal_x/y/z, normal_x/y/z (lowest first)
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [143:0]      m_tdata,
  output logic              m_tuser    // uv_degenerate
);
  localparam int POS_W  = ttf_pkg::POS_W;
  localparam int TEX_W  = ttf_pkg::TEX_W;
  localparam int VEC_W  = ttf_pkg::VEC_W;
  localparam int EDGE_W = ttf_pkg::EDGE_W;
  localparam int DTEX_W = ttf_pkg::DTEX_W;
  localparam int DET_W  = ttf_pkg::DET_W;
  localparam int RAW_W  = ttf_pkg::RAW_W;
  localparam int MUL_W  = ttf_pkg::MUL_W;
  localparam int ACC_W  = ttf_pkg::ACC_W;
  localparam int DIV_W  = ttf_pkg::DIV_W;
  localparam int Q_W    = ttf_pkg::Q_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIFF   = 4'd1;
  localparam logic [3:0] ST_MUL    = 4'd2;
  localparam logic [3:0] ST_NSET   = 4'd3;
  localparam logic [3:0] ST_NSHIFT = 4'd4;
  localparam logic [3:0] ST_NSQ    = 4'd5;
  localparam logic [3:0] ST_NSQRT  = 4'd6;
  localparam logic [3:0] ST_NLOAD  = 4'd7;
  localparam logic [3:0] ST_NDIV   = 4'd8;
  localparam logic [3:0] ST_OUT    = 4'd9;

  logic [3:0] state;
  logic [1:0] corner;
  logic [ttf_pkg::EPS_W-1:0] eps;

  // held corners and the current one
  logic signed [POS_W-1:0] hp [0:5];
  logic signed [TEX_W-1:0] ht [0:3];
  logic signed [POS_W-1:0] cp [0:2];
  logic signed [TEX_W-1:0] cu, cv;

  logic signed [EDGE_W-1:0] e1 [0:2];
  logic signed [EDGE_W-1:0] e2 [0:2];
  logic signed [DTEX_W-1:0] du1, dv1, du2, dv2;

  // shared multiplier and accumulator
  logic [4:0] mstep;
  logic       ph;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [ACC_W-1:0] prod, acc, acc_sub;

  logic                    degen, neg;
  logic signed [RAW_W-1:0] tv [0:2];
  logic signed [RAW_W-1:0] bv [0:2];
  logic signed [RAW_W-1:0] cr [0:2];
  logic signed [VEC_W-1:0] tn [0:2];
  logic signed [VEC_W-1:0] bn [0:2];
  logic signed [VEC_W-1:0] nn [0:2];

  // normalizer
  logic [1:0] job, nk;
  logic [RAW_W-1:0] nm [0:2];
  logic             nsg [0:2];
  logic [RAW_W-1:0] vabs [0:2];
  logic signed [RAW_W-1:0] vin [0:2];
  logic [RAW_W-1:0] m_or;
  logic [ACC_W-1:0] sx, sres, sbit, stry;
  logic [DIV_W-1:0] drem, dsh;
  logic [Q_W-1:0]   dq, q_fin, q_sat;
  logic [4:0]       dj;
  logic             dge;
  logic signed [VEC_W-1:0] q_val;
  logic [ttf_pkg::DET_W-1:0] adet;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  // operand select for the multiply sequence; even steps load, odd steps subtract
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_NSQ) begin
      mul_a = MUL_W'(nm[nk][ttf_pkg::MAG_TOP:0]);
      mul_b = MUL_W'(nm[nk][ttf_pkg::MAG_TOP:0]);
    end else begin
      case (mstep)
        5'd0:  begin mul_a = MUL_W'(du1);   mul_b = MUL_W'(dv2);   end
        5'd1:  begin mul_a = MUL_W'(du2);   mul_b = MUL_W'(dv1);   end
        5'd2:  begin mul_a = MUL_W'(dv2);   mul_b = MUL_W'(e1[0]); end
        5'd3:  begin mul_a = MUL_W'(dv1);   mul_b = MUL_W'(e2[0]); end
        5'd4:  begin mul_a = MUL_W'(dv2);   mul_b = MUL_W'(e1[1]); end
        5'd5:  begin mul_a = MUL_W'(dv1);   mul_b = MUL_W'(e2[1]); end
        5'd6:  begin mul_a = MUL_W'(dv2);   mul_b = MUL_W'(e1[2]); end
        5'd7:  begin mul_a = MUL_W'(dv1);   mul_b = MUL_W'(e2[2]); end
        5'd8:  begin mul_a = MUL_W'(du1);   mul_b = MUL_W'(e2[0]); end
        5'd9:  begin mul_a = MUL_W'(du2);   mul_b = MUL_W'(e1[0]); end
        5'd10: begin mul_a = MUL_W'(du1);   mul_b = MUL_W'(e2[1]); end
        5'd11: begin mul_a = MUL_W'(du2);   mul_b = MUL_W'(e1[1]); end
        5'd12: begin mul_a = MUL_W'(du1);   mul_b = MUL_W'(e2[2]); end
        5'd13: begin mul_a = MUL_W'(du2);   mul_b = MUL_W'(e1[2]); end
        5'd14: begin mul_a = MUL_W'(tn[1]); mul_b = MUL_W'(bn[2]); end
        5'd15: begin mul_a = MUL_W'(tn[2]); mul_b = MUL_W'(bn[1]); end
        5'd16: begin mul_a = MUL_W'(tn[2]); mul_b = MUL_W'(bn[0]); end
        5'd17: begin mul_a = MUL_W'(tn[0]); mul_b = MUL_W'(bn[2]); end
        5'd18: begin mul_a = MUL_W'(tn[0]); mul_b = MUL_W'(bn[1]); end
        5'd19: begin mul_a = MUL_W'(tn[1]); mul_b = MUL_W'(bn[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign acc_sub = acc - prod;
  assign adet    = acc_sub[DET_W-1] ? DET_W'(-acc_sub) : DET_W'(acc_sub);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (job)
        ttf_pkg::JOB_TAN: vin[i] = tv[i];
        ttf_pkg::JOB_BIN: vin[i] = bv[i];
        default:          vin[i] = cr[i];
      endcase
      vabs[i] = vin[i][RAW_W-1] ? RAW_W'(-vin[i]) : RAW_W'(vin[i]);
    end
  end

  assign m_or  = nm[0] | nm[1] | nm[2];
  assign stry  = sres + sbit;
  assign dsh   = DIV_W'(sres[31:0]) << dj;
  assign dge   = (drem >= dsh);
  assign q_fin = dq | (Q_W'(dge) << dj);
  assign q_sat = (q_fin > ttf_pkg::QMAX) ? ttf_pkg::QMAX : q_fin;
  assign q_val = nsg[nk] ? -VEC_W'(q_sat) : VEC_W'(q_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      corner   <= 2'd0;
      eps      <= ttf_pkg::EPS_RESET;
      m_tvalid <= 1'b0;
      ph       <= 1'b0;
      mstep    <= '0;
      job      <= ttf_pkg::JOB_TAN;
      nk       <= '0;
    end else begin
      if (cfg_valid && cfg_ready)
        eps <= cfg_data;
      // ST_OUT reloads the register itself when it hands over
      if (m_tvalid && m_tready && state != ST_OUT)
        m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (corner != 2'd2) begin
              for (int i = 0; i < 3; i++)
                hp[(corner[0] ? 3 : 0) + i] <= s_tdata[i*POS_W +: POS_W];
              ht[corner[0] ? 2 : 0] <= s_tdata[3*POS_W +: TEX_W];
              ht[corner[0] ? 3 : 1] <= s_tdata[3*POS_W+TEX_W +: TEX_W];
              corner <= s_tlast ? 2'd0 : corner + 2'd1;
            end else begin
              for (int i = 0; i < 3; i++)
                cp[i] <= s_tdata[i*POS_W +: POS_W];
              cu     <= s_tdata[3*POS_W +: TEX_W];
              cv     <= s_tdata[3*POS_W+TEX_W +: TEX_W];
              corner <= 2'd0;
              state  <= ST_DIFF;
            end
          end
        end

        ST_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            e1[i] <= EDGE_W'(hp[3+i]) - EDGE_W'(hp[i]);
            e2[i] <= EDGE_W'(cp[i]) - EDGE_W'(hp[i]);
          end
          du1   <= DTEX_W'(ht[2]) - DTEX_W'(ht[0]);
          dv1   <= DTEX_W'(ht[3]) - DTEX_W'(ht[1]);
          du2   <= DTEX_W'(cu) - DTEX_W'(ht[0]);
          dv2   <= DTEX_W'(cv) - DTEX_W'(ht[1]);
          mstep <= '0;
          ph    <= 1'b0;
          state <= ST_MUL;
        end

        ST_MUL: begin
          if (!ph) begin
            prod <= mul_a * mul_b;
            ph   <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (!mstep[0]) begin
              acc   <= prod;
              mstep <= mstep + 5'd1;
            end else begin
              case (mstep)
                5'd1: begin
                  degen <= (adet < DET_W'(eps));
                  neg   <= !(adet < DET_W'(eps)) && acc_sub[ACC_W-1];
                end
                5'd3:  tv[0] <= neg ? -RAW_W'(acc_sub) : RAW_W'(acc_sub);
                5'd5:  tv[1] <= neg ? -RAW_W'(acc_sub) : RAW_W'(acc_sub);
                5'd7:  tv[2] <= neg ? -RAW_W'(acc_sub) : RAW_W'(acc_sub);
                5'd9:  bv[0] <= neg ? -RAW_W'(acc_sub) : RAW_W'(acc_sub);
                5'd11: bv[1] <= neg ? -RAW_W'(acc_sub) : RAW_W'(acc_sub);
                5'd13: bv[2] <= neg ? -RAW_W'(acc_sub) : RAW_W'(acc_sub);
                5'd15: cr[0] <= RAW_W'(acc_sub);
                5'd17: cr[1] <= RAW_W'(acc_sub);
                5'd19: cr[2] <= RAW_W'(acc_sub);
                default: ;
              endcase
              mstep <= mstep + 5'd1;
              if (mstep == 5'd13) begin
                job   <= ttf_pkg::JOB_TAN;
                state <= ST_NSET;
              end else if (mstep == 5'(ttf_pkg::MSTEP_LAST)) begin
                job   <= ttf_pkg::JOB_NRM;
                state <= ST_NSET;
              end
            end
          end
        end

        // magnitudes and signs; a zero vector finishes at once
        ST_NSET: begin
          for (int i = 0; i < 3; i++) begin
            nm[i]  <= vabs[i];
            nsg[i] <= vin[i][RAW_W-1];
          end
          nk <= '0;
          if ((vabs[0] | vabs[1] | vabs[2]) == '0) begin
            for (int i = 0; i < 3; i++) begin
              case (job)
                ttf_pkg::JOB_TAN: tn[i] <= '0;
                ttf_pkg::JOB_BIN: bn[i] <= '0;
                default:          nn[i] <= '0;
              endcase
            end
            case (job)
              ttf_pkg::JOB_TAN: begin job <= ttf_pkg::JOB_BIN; state <= ST_NSET; end
              ttf_pkg::JOB_BIN: begin
                mstep <= 5'(ttf_pkg::MSTEP_CROSS);
                ph    <= 1'b0;
                state <= ST_MUL;
              end
              default: state <= ST_OUT;
            endcase
          end else begin
            state <= ST_NSHIFT;
          end
        end

        // align the largest magnitude to [2^29, 2^30), one bit a cycle
        ST_NSHIFT: begin
          if (m_or[RAW_W-1:ttf_pkg::MAG_TOP+1] != '0) begin
            for (int i = 0; i < 3; i++) nm[i] <= nm[i] >> 1;
          end else if (!m_or[ttf_pkg::MAG_TOP]) begin
            for (int i = 0; i < 3; i++) nm[i] <= nm[i] << 1;
          end else begin
            ph    <= 1'b0;
            state <= ST_NSQ;
          end
        end

        ST_NSQ: begin
          if (!ph) begin
            prod <= mul_a * mul_b;
            ph   <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (nk == 2'd2) begin
              sx    <= ACC_W'(acc + prod);
              sres  <= '0;
              sbit  <= ACC_W'(1) << 62;
              nk    <= '0;
              state <= ST_NSQRT;
            end else begin
              acc <= (nk == 2'd0) ? prod : acc + prod;
              nk  <= nk + 2'd1;
            end
          end
        end

        // bit-pair integer square root, one result bit a cycle
        ST_NSQRT: begin
          if (sx >= stry) begin
            sx   <= sx - stry;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit == ACC_W'(1))
            state <= ST_NLOAD;
        end

        ST_NLOAD: begin
          drem  <= (DIV_W'(nm[nk][ttf_pkg::MAG_TOP:0]) << (VEC_W - 1))
                   + DIV_W'(sres[31:1]);
          dq    <= '0;
          dj    <= 5'(ttf_pkg::Q_TOP);
          state <= ST_NDIV;
        end

        // restoring divide by the length, one quotient bit a cycle
        ST_NDIV: begin
          if (dge)
            drem <= drem - dsh;
          dq <= q_fin;
          if (dj != 5'd0) begin
            dj <= dj - 5'd1;
          end else begin
            case (job)
              ttf_pkg::JOB_TAN: tn[nk] <= q_val;
              ttf_pkg::JOB_BIN: bn[nk] <= q_val;
              default:          nn[nk] <= q_val;
            endcase
            if (nk != 2'd2) begin
              nk    <= nk + 2'd1;
              state <= ST_NLOAD;
            end else begin
              case (job)
                ttf_pkg::JOB_TAN: begin job <= ttf_pkg::JOB_BIN; state <= ST_NSET; end
                ttf_pkg::JOB_BIN: begin
                  mstep <= 5'(ttf_pkg::MSTEP_CROSS);
                  ph    <= 1'b0;
                  state <= ST_MUL;
                end
                default: state <= ST_OUT;
              endcase
            end
          end
        end

        // hand over to the output register once it is free
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {nn[2], nn[1], nn[0], bn[2], bn[1], bn[0], tn[2], tn[1], tn[0]};
            m_tuser  <= degen;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  a_corner_range: assert property (@(posedge clk) disable iff (rst) corner != 2'd3)
    else $error("corner count out of range");
  a_aligned: assert property (@(posedge clk) disable iff (rst)
    state == ST_NSQ |-> (m_or[RAW_W-1:ttf_pkg::MAG_TOP+1] == '0 && m_or[ttf_pkg::MAG_TOP]))
    else $error("magnitudes not aligned before squaring");
  a_len_floor: assert property (@(posedge clk) disable iff (rst)
    state == ST_NDIV |-> sres[31:ttf_pkg::MAG_TOP] != '0)
    else $error("vector length below alignment floor");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] != 16'h8000 && m_tdata[143:128] != 16'h8000))
    else $error("component outside saturation range");
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_OUT)
    else $error("result shown without finishing a triangle");
endmodule
`default_nettype wire

// ===== tb/sv/ttf_frame_checker.sv =====
// Frame checker: watches the vertex and frame streams, predicts frames, compares.
`timescale 1ns / 1ps
module ttf_frame_checker
  import ttf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [19:0]  cfg_data,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [111:0] s_tdata,
  input  wire logic         s_tlast,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [143:0] m_tdata,
  input  wire logic         m_tuser,
  output int                fail_count,
  output int                frames_pending
);

  typedef struct packed {
    logic         degen;
    logic [143:0] vecs;
  } frame_t;

  frame_t frame_q[$];
  logic [EPS_W-1:0] epsilon;
  logic [1:0] corners;
  longint hp[6];
  longint ht[4];
  string field_name[9] = '{"tangent_x", "tangent_y", "tangent_z",
                           "binormal_x", "binormal_y", "binormal_z",
                           "normal_x", "normal_y", "normal_z"};

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  task automatic unit_vec(input longint c[3], output longint o[3]);
    longint unsigned m[3], mx, sum, len, q;
    longint unsigned qmax;
    int top;
    qmax = (64'd1 << (VEC_W - 1)) - 1;
    mx = 0;
    sum = 0;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o[0] = 0; o[1] = 0; o[2] = 0;
      return;
    end
    while (top < 63 && (mx >> (top + 1)) != 0) top++;
    for (int i = 0; i < 3; i++) begin
      if (top > MAG_TOP) m[i] >>= (top - MAG_TOP);
      else m[i] <<= (MAG_TOP - top);
      sum += m[i] * m[i];
    end
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << (VEC_W - 1)) + (len >> 1)) / len;
      if (q > qmax) q = qmax;
      o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
  endtask

  task automatic take_vertex(input logic [111:0] d, input logic last);
    longint p[3], u, v, e1[3], e2[3], du1, du2, dv1, dv2, det, adet;
    longint t[3], b[3], tn[3], bn[3], cr[3], nn[3];
    logic degen;
    frame_t f;
    for (int i = 0; i < 3; i++) p[i] = longint'($signed(d[i*POS_W +: POS_W]));
    u = longint'($signed(d[3*POS_W +: TEX_W]));
    v = longint'($signed(d[3*POS_W+TEX_W +: TEX_W]));
    if (corners < 2) begin
      for (int i = 0; i < 3; i++) hp[corners[0]*3 + i] = p[i];
      ht[corners[0]*2] = u;
      ht[corners[0]*2 + 1] = v;
      corners = last ? 2'd0 : corners + 2'd1;
      return;
    end
    corners = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = hp[3+i] - hp[i];
      e2[i] = p[i] - hp[i];
    end
    du1 = ht[2] - ht[0];
    dv1 = ht[3] - ht[1];
    du2 = u - ht[0];
    dv2 = v - ht[1];
    det = du1 * dv2 - du2 * dv1;
    adet = det < 0 ? -det : det;
    degen = adet < longint'(epsilon);
    for (int i = 0; i < 3; i++) begin
      t[i] = dv2 * e1[i] - dv1 * e2[i];
      b[i] = du1 * e2[i] - du2 * e1[i];
      if (!degen && det < 0) begin
        t[i] = -t[i];
        b[i] = -b[i];
      end
    end
    unit_vec(t, tn);
    unit_vec(b, bn);
    cr[0] = tn[1] * bn[2] - tn[2] * bn[1];
    cr[1] = tn[2] * bn[0] - tn[0] * bn[2];
    cr[2] = tn[0] * bn[1] - tn[1] * bn[0];
    unit_vec(cr, nn);
    for (int i = 0; i < 3; i++) begin
      f.vecs[i*VEC_W +: VEC_W] = tn[i][VEC_W-1:0];
      f.vecs[(3+i)*VEC_W +: VEC_W] = bn[i][VEC_W-1:0];
      f.vecs[(6+i)*VEC_W +: VEC_W] = nn[i][VEC_W-1:0];
    end
    f.degen = degen;
    frame_q.push_back(f);
  endtask

  initial begin
    fail_count = 0;
    frames_pending = 0;
  end

  always @(posedge clk) begin
    frame_t exp_f;
    if (rst) begin
      epsilon = EPS_RESET;
      corners = 0;
      frame_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) epsilon = cfg_data;
      if (m_tvalid && m_tready) begin
        if (frame_q.size() == 0) begin
          $error("unexpected frame %h", m_tdata);
          fail_count++;
        end else begin
          exp_f = frame_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_tdata[i*VEC_W +: VEC_W] !== exp_f.vecs[i*VEC_W +: VEC_W]) begin
              $error("%s: exp %0d got %0d", field_name[i],
                     $signed(exp_f.vecs[i*VEC_W +: VEC_W]),
                     $signed(m_tdata[i*VEC_W +: VEC_W]));
              fail_count++;
            end
          if (m_tuser !== exp_f.degen) begin
            $error("uv_degenerate: exp %0b got %0b", exp_f.degen, m_tuser);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) take_vertex(s_tdata, s_tlast);
    end
    frames_pending = frame_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top: vertex stimulus, frame sink, threshold writes and verdict.
`timescale 1ns / 1ps
module testbench;
  import ttf_pkg::*;

  localparam int LIMIT = 3_000_000;  // timeout, in cycles
  localparam int DRAIN = 500;        // exceeds worst-case frame latency

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [19:0]  cfg_data = '0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         s_tlast = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [143:0] m_tdata;
  logic         m_tuser;
  int fail_count, frames_pending;
  int cycle = 0;
  bit no_idle = 0;    // long stretch with no gaps on either side
  bit hold_sink = 0;  // receiver held off to back up the block

  triangle_tangent_frame_top dut (.*);

  ttf_frame_checker chk (.*);

  initial forever #10 clk = ~clk;

  // timeout
  always @(posedge clk) begin
    cycle++;
    if (cycle > LIMIT) begin
      $display("** triangle_tangent_frame_top: FAILED **");
      $finish;
    end
  end

  // sink: random stalls, or a long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_sink) m_tready <= 0;
      else m_tready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  // one long hold-off, counted here while the source keeps offering
  initial begin
    wait (!rst);
    repeat (30000) @(negedge clk);
    hold_sink = 1;
    repeat (3000) @(negedge clk);
    hold_sink = 0;
  end

  // random vertex; small ranges make near-repeat and degenerate UVs likely
  function automatic logic [111:0] rand_vertex();
    logic [111:0] d;
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < 3; i++)
      d[i*POS_W +: POS_W] = (mode == 0) ? POS_W'($urandom_range(7)) : POS_W'($urandom);
    for (int i = 0; i < 2; i++)
      d[3*POS_W + i*TEX_W +: TEX_W] = (mode == 1) ? TEX_W'($urandom_range(3))
                                                   : TEX_W'($urandom);
    return d;
  endfunction

  // valid stays up after the handshake until the next call or settle drops it
  task automatic send_vertex(input logic [111:0] d, input logic last);
    while (!no_idle && $urandom_range(99) < 31) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= d;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait for all frames, then the DRAIN wait, before a threshold write
  task automatic settle();
    s_tvalid <= 0;
    while (frames_pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_epsilon(input logic [19:0] val);
    cfg_valid <= 1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [111:0] vtx(int x, int y, int z, int u, int v);
    return {TEX_W'(v), TEX_W'(u), POS_W'(z), POS_W'(y), POS_W'(x)};
  endfunction

  localparam int PMAX = 8388607, PMIN = -8388608, TMAX = 524287, TMIN = -524288;
  localparam int EPS_SET[4] = '{0, 1048575, 1, 4295};

  initial begin
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: reset threshold first
    // ordinary triangle
    send_vertex(vtx(0, 0, 0, 0, 0), 1'b0);
    send_vertex(vtx(65536, 0, 0, 65536, 0), 1'b0);
    send_vertex(vtx(0, 65536, 0, 0, 65536), 1'b0);
    // negative determinant
    send_vertex(vtx(0, 0, 0, 0, 0), 1'b0);
    send_vertex(vtx(65536, 0, 0, 0, 65536), 1'b0);
    send_vertex(vtx(0, 65536, 0, 65536, 0), 1'b0);
    // position extremes, texture extremes
    send_vertex(vtx(PMIN, PMIN, PMIN, TMIN, TMIN), 1'b0);
    send_vertex(vtx(PMAX, PMAX, PMIN, TMAX, TMIN), 1'b0);
    send_vertex(vtx(PMIN, PMAX, PMAX, TMIN, TMAX), 1'b1);  // last on third corner
    // degenerate UV: all equal -> zero vectors, zero normal
    send_vertex(vtx(5, 6, 7, 100, 100), 1'b0);
    send_vertex(vtx(9, 1, 2, 100, 100), 1'b0);
    send_vertex(vtx(3, 8, 4, 100, 100), 1'b0);
    // zero-length edges with good UV
    send_vertex(vtx(1, 1, 1, 0, 0), 1'b0);
    send_vertex(vtx(1, 1, 1, 65536, 0), 1'b0);
    send_vertex(vtx(1, 1, 1, 0, 65536), 1'b0);
    // last mark mid-triangle on first and on second corner
    send_vertex(vtx(PMAX, 0, 0, TMAX, 0), 1'b1);
    send_vertex(vtx(1, 2, 3, 4, 5), 1'b0);
    send_vertex(vtx(PMIN, 2, 3, 4, TMAX), 1'b1);
    settle();

    // zero threshold with zero determinant: counts as not degenerate
    write_epsilon(20'(EPS_SET[0]));
    send_vertex(vtx(0, 0, 0, 7, 7), 1'b0);
    send_vertex(vtx(65536, 0, 0, 7, 7), 1'b0);
    send_vertex(vtx(0, 65536, 0, 7, 7), 1'b0);
    settle();

    // random phases over several thresholds
    for (int ph = 0; ph < 4; ph++) begin
      write_epsilon(ph == 3 ? 20'($urandom) : 20'(EPS_SET[ph]));
      for (int n = 0; n < 115; n++) begin
        no_idle = (ph == 2 && n < 40);
        if ($urandom_range(9) == 0) begin
          // broken triangle
          send_vertex(rand_vertex(), 1'($urandom_range(1)));
        end else begin
          send_vertex(rand_vertex(), 1'b0);
          send_vertex(rand_vertex(), 1'b0);
          send_vertex(rand_vertex(), $urandom_range(7) == 0);
        end
      end
      no_idle = 0;
      // sender pauses until every frame has come
      settle();
    end
    write_epsilon(EPS_RESET);

    settle();
    if (fail_count == 0) $display("** triangle_tangent_frame_top: PASSED **");
    else $display("** triangle_tangent_frame_top: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ttf_pkg.sv
rtl/triangle_tangent_frame_top.sv
tb/sv/ttf_frame_checker.sv
tb/sv/testbench.sv
